// ----- design/assert_macros.svh -----
// Assertion macros used by the scanner top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: label");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/kdes_pkg.sv -----
// Shared constants and types of the keypad debounce event scanner.
package kdes_pkg;
   localparam int NUM_MUXED_KEYS    = 6;
   localparam int NUM_DIRECT_KEYS   = 3;
   localparam int NUM_KEYS          = NUM_MUXED_KEYS + NUM_DIRECT_KEYS;
   localparam int KEY_W             = 4;
   localparam int NOW_W             = 32;
   localparam int MUX_W             = 3;
   localparam int LINE_W            = 3;
   localparam int LINE_IDX_W        = 2;
   localparam int OUT_W             = 9;
   localparam int DEB_W             = 8;
   localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd1;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_PRESSED,
      PHASE_RELEASED
   } phase_type;

   typedef struct packed {
      logic             level;
      logic             pending;
      logic [NOW_W-1:0] mark;
      phase_type        phase;
   } key_state_type;

   typedef struct packed {
      logic press;
      logic release_ev;
      logic pressed;
   } key_event_type;
endpackage

// ----- design/kdes_req_if.sv -----
// Scan request channel: time stamp, mux pins and direct lines.
interface kdes_req_if import kdes_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [NOW_W-1:0]  now_ms;
   logic [MUX_W-1:0]  mux_pins;
   logic [LINE_W-1:0] direct_lines;

   modport source(output valid, output now_ms, output mux_pins, output direct_lines,
                  input ready);
   modport sink(input valid, input now_ms, input mux_pins, input direct_lines,
                output ready);
endinterface

// ----- design/kdes_rsp_if.sv -----
// Scan result channel: press, release and pressed masks.
interface kdes_rsp_if import kdes_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] press_events;
   logic [OUT_W-1:0] release_events;
   logic [OUT_W-1:0] pressed_mask;

   modport source(output valid, output press_events, output release_events,
                  output pressed_mask, input ready);
   modport sink(input valid, input press_events, input release_events,
                input pressed_mask, output ready);
endinterface

// ----- design/keypad_debounce_event_scanner.sv -----
// Top level of the keypad debounce event scanner: sequencer and key state.
//
// Usage: each beat on req_ch is one keypad scan with a millisecond time stamp,
// the three active-low mux select pins and the direct return lines. Each scan
// yields exactly one beat on rsp_ch with the press-event mask, the release-
// event mask and the mask of keys in the pressed phase (muxed keys in bits
// 0 to 5, direct keys in bits 6 to 8).
// The debounce time is written through csr_we/csr_wdata; the user must write
// it only while idle, which the block does not enforce. Zero is stored as one.
// Reset value is one millisecond. One shared key unit walks the nine keys,
// one key per cycle. The result appears on rsp_ch in the same cycle that
// req_ch.ready returns, so a new scan is taken only after the last one has
// gone into the output register.
// The result sits in an output register: the next scan is accepted while
// a result still waits. If the receiver stalls, the finished scan holds
// before the output register until it frees, and req_ch.ready stays low.
// Reset (synchronous, active high) sets all keys open, idle, no check
// pending, and drops any result in flight.
module keypad_debounce_event_scanner import kdes_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [DEB_W-1:0] csr_wdata,
   kdes_req_if.sink         req_ch,
   kdes_rsp_if.source       rsp_ch
);
`include "assert_macros.svh"

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_LOAD
   } state_type;

   state_type         state_ff, state_in;
   logic [KEY_W-1:0]  key_idx_ff, key_idx_in;
   logic [DEB_W-1:0]  debounce_ff, debounce_in;
   logic [NOW_W-1:0]  now_ff;
   logic [MUX_W-1:0]  code_ff;
   logic [LINE_W-1:0] lines_ff;
   logic [NUM_KEYS-1:0] press_acc_ff, press_acc_in;
   logic [NUM_KEYS-1:0] release_acc_ff, release_acc_in;
   logic [NUM_KEYS-1:0] pressed_acc_ff, pressed_acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_press_ff, rsp_press_in;
   logic [OUT_W-1:0]  rsp_release_ff, rsp_release_in;
   logic [OUT_W-1:0]  rsp_pressed_ff, rsp_pressed_in;
   key_state_type     key_ff [NUM_KEYS];
   key_state_type     unit_nxt;
   key_event_type     unit_evt;
   logic              req_beat;

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign req_beat              = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.press_events   = rsp_press_ff;
   assign rsp_ch.release_events = rsp_release_ff;
   assign rsp_ch.pressed_mask   = rsp_pressed_ff;

   kdes_key_unit u_key_unit (
      .key_idx     (key_idx_ff),
      .code        (code_ff),
      .lines       (lines_ff),
      .now_ms      (now_ff),
      .debounce_ms (debounce_ff),
      .cur         (key_ff[key_idx_ff]),
      .nxt         (unit_nxt),
      .evt         (unit_evt)
   );

   always_comb begin
      state_in       = state_ff;
      key_idx_in     = key_idx_ff;
      debounce_in    = debounce_ff;
      press_acc_in   = press_acc_ff;
      release_acc_in = release_acc_ff;
      pressed_acc_in = pressed_acc_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_press_in   = rsp_press_ff;
      rsp_release_in = rsp_release_ff;
      rsp_pressed_in = rsp_pressed_ff;
      if (csr_we) begin
         debounce_in = (csr_wdata == '0) ? DEBOUNCE_RESET : csr_wdata;
      end
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               state_in       = S_SCAN;
               key_idx_in     = '0;
               press_acc_in   = '0;
               release_acc_in = '0;
               pressed_acc_in = '0;
            end
         end
         S_SCAN: begin
            press_acc_in[key_idx_ff]   = unit_evt.press;
            release_acc_in[key_idx_ff] = unit_evt.release_ev;
            pressed_acc_in[key_idx_ff] = unit_evt.pressed;
            if (key_idx_ff == KEY_W'(NUM_KEYS - 1)) begin
               state_in = S_LOAD;
            end else begin
               key_idx_in = key_idx_ff + KEY_W'(1);
            end
         end
         S_LOAD: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_press_in   = press_acc_ff[OUT_W-1:0];
               rsp_release_in = release_acc_ff[OUT_W-1:0];
               rsp_pressed_in = pressed_acc_ff[OUT_W-1:0];
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_idx_ff   <= '0;
         debounce_ff  <= DEBOUNCE_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_KEYS; i++) begin
            key_ff[i] <= '{level: 1'b0, pending: 1'b0, mark: '0, phase: PHASE_IDLE};
         end
      end else begin
         state_ff     <= state_in;
         key_idx_ff   <= key_idx_in;
         debounce_ff  <= debounce_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_SCAN) begin
            key_ff[key_idx_ff] <= unit_nxt;
         end
      end
      if (req_beat) begin
         now_ff   <= req_ch.now_ms;
         code_ff  <= ~req_ch.mux_pins;
         lines_ff <= req_ch.direct_lines;
      end
      press_acc_ff   <= press_acc_in;
      release_acc_ff <= release_acc_in;
      pressed_acc_ff <= pressed_acc_in;
      rsp_press_ff   <= rsp_press_in;
      rsp_release_ff <= rsp_release_in;
      rsp_pressed_ff <= rsp_pressed_in;
   end

   `ASSERT_ALWAYS(a_key_in_range, clock, reset, key_idx_ff < KEY_W'(NUM_KEYS))
   `ASSERT_ALWAYS(a_debounce_nonzero, clock, reset, debounce_ff != '0)
   `ASSERT_NEXT(a_scan_starts, clock, reset, req_beat, state_ff == S_SCAN && key_idx_ff == '0)
   `ASSERT_IMPLIES(a_press_is_pressed, clock, reset, rsp_valid_ff, (rsp_press_ff & ~rsp_pressed_ff) == '0)
   `ASSERT_IMPLIES(a_events_disjoint, clock, reset, rsp_valid_ff, (rsp_press_ff & rsp_release_ff) == '0)
endmodule

// ----- design/kdes_key_unit.sv -----
// Shared per-key unit: sample decode, time compare, debounce and phase update.
module kdes_key_unit import kdes_pkg::*; (
   input  logic [KEY_W-1:0]  key_idx,
   input  logic [MUX_W-1:0]  code,
   input  logic [LINE_W-1:0] lines,
   input  logic [NOW_W-1:0]  now_ms,
   input  logic [DEB_W-1:0]  debounce_ms,
   input  key_state_type     cur,
   output key_state_type     nxt,
   output key_event_type     evt
);
   logic             closed;
   logic [KEY_W-1:0] direct_idx;
   logic [NOW_W-1:0] diff;
   logic [NOW_W-1:0] mag;
   logic             expired;

   assign direct_idx = key_idx - KEY_W'(NUM_MUXED_KEYS);
   assign diff       = now_ms - cur.mark;
   assign mag        = diff[NOW_W-1] ? (~diff + NOW_W'(1)) : diff;
   assign expired    = mag >= {{(NOW_W-DEB_W){1'b0}}, debounce_ms};

   always_comb begin
      if (key_idx < KEY_W'(NUM_MUXED_KEYS)) begin
         closed = (code != '0) && ({1'b0, code} == key_idx + KEY_W'(1));
      end else if (direct_idx < KEY_W'(LINE_W)) begin
         closed = !lines[direct_idx[LINE_IDX_W-1:0]];
      end else begin
         closed = 1'b0;
      end
   end

   always_comb begin
      nxt = cur;
      evt = '0;
      if (closed != cur.level) begin
         if (cur.pending) begin
            if (expired) begin
               nxt.level   = !cur.level;
               nxt.pending = 1'b0;
            end
         end else begin
            nxt.mark    = now_ms;
            nxt.pending = 1'b1;
         end
      end else begin
         nxt.pending = 1'b0;
      end
      case (cur.phase)
         PHASE_IDLE: begin
            if (nxt.level) begin
               nxt.phase = PHASE_PRESSED;
               evt.press = 1'b1;
            end
         end
         PHASE_PRESSED: begin
            if (!nxt.level) begin
               nxt.phase      = PHASE_RELEASED;
               evt.release_ev = 1'b1;
            end
         end
         default: begin
            nxt.phase = PHASE_IDLE;
         end
      endcase
      evt.pressed = (nxt.phase == PHASE_PRESSED);
   end
endmodule
